// ===== src/pngse_pkg.sv =====
// Shared constants and the CRC-32 byte update for the PNG stored-stream encoder.
// No dependencies; imported by the encoder core.
package pngse_pkg;

    localparam int unsigned STORED_BLOCK_MAX_DEF = 65535;
    localparam int unsigned WIDTH_MAX_DEF        = 16384;
    localparam int unsigned HEIGHT_MAX_DEF       = 16384;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    // CRC-32 of the fixed IEND chunk (type only, empty data)
    localparam logic [31:0] IEND_CRC  = 32'hAE426082;

    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam int RAW_W = 30;

    typedef logic [31:0] crc_t;

    // Reflected CRC-32, one byte in
    function automatic crc_t crc_feed(input crc_t c_in, input logic [7:0] b);
        crc_t c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/png_stored_stream_encoder_core.sv =====
// Streaming PNG writer (RGB, 8 bit) using stored DEFLATE blocks, top level.
// Depends on pngse_pkg for constants and the CRC-32 byte update.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets image_width
//   (index 0) and image_height (index 1); always ready, writes are dropped
//   while an image is in progress. Values clamp to 1..maximum.
//   in channel carries raw colour bytes, R G B, rows top to bottom.
//   out channel carries the PNG file, one byte per transaction; run_last marks
//   the last byte caused by an input byte, file_last the last byte of IEND.
// Latency and throughput:
//   The first byte caused by an input appears on out in the cycle after the
//   transaction. A byte sequencer emits one output byte per cycle unless out stalls;
//   the bytes an input causes are 1 for a plain pixel byte, 2 at a row start,
//   +5 at a stored-block start, +43 at image start, +20 at image end. The next
//   input can be taken while the previous run's last byte is on out, so plain
//   pixel bytes flow at one per cycle while out_ready stays high.
//   The IDAT block count comes from a reciprocal multiplication registered the
//   cycle after image start, well before the length bytes are due.
// Reset: control state clears, width and height return to 1, out goes empty.
// Stall: while out holds a byte and out_ready is low, the output register holds and the
//   sequencer and in_ready stop.
module png_stored_stream_encoder_core #(
    parameter int unsigned STORED_BLOCK_MAX = pngse_pkg::STORED_BLOCK_MAX_DEF,
    parameter int unsigned WIDTH_MAX        = pngse_pkg::WIDTH_MAX_DEF,
    parameter int unsigned HEIGHT_MAX       = pngse_pkg::HEIGHT_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        file_last
);
    import pngse_pkg::*;

    localparam int unsigned BLOCK_EFF = (STORED_BLOCK_MAX < 2) ? 2 : STORED_BLOCK_MAX;
    localparam logic [15:0] BLK_D = 16'(BLOCK_EFF);
    // ceil(x / BLOCK_EFF) = floor((x + BLOCK_EFF - 1) * DIV_M >> DIV_SH) for 30-bit x
    localparam int DIV_SH = 31 + $clog2(BLOCK_EFF);
    localparam longint unsigned DIV_M_FULL =
        ((64'd1 << DIV_SH) + 64'(BLOCK_EFF) - 64'd1) / 64'(BLOCK_EFF);
    localparam logic [31:0] DIV_M = 32'(DIV_M_FULL);

    // sequencer phases
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_SIG   = 4'd1;
    localparam logic [3:0] PH_IHLEN = 4'd2;
    localparam logic [3:0] PH_IHTAG = 4'd3;
    localparam logic [3:0] PH_IHDAT = 4'd4;
    localparam logic [3:0] PH_IHCRC = 4'd5;
    localparam logic [3:0] PH_ZLEN  = 4'd6;
    localparam logic [3:0] PH_IDTAG = 4'd7;
    localparam logic [3:0] PH_ZHDR  = 4'd8;
    localparam logic [3:0] PH_BLKH  = 4'd9;
    localparam logic [3:0] PH_FILT  = 4'd10;
    localparam logic [3:0] PH_PIX   = 4'd11;
    localparam logic [3:0] PH_ADLER = 4'd12;
    localparam logic [3:0] PH_DCRC  = 4'd13;
    localparam logic [3:0] PH_IEND  = 4'd14;

    logic [14:0]      width_reg, width_next;
    logic [14:0]      height_reg, height_next;
    logic [3:0]       phase_reg, phase_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             filt_reg, filt_next;
    logic [7:0]       pix_reg, pix_next;
    logic             started_reg, started_next;
    logic [15:0]      row_pos_reg, row_pos_next;
    logic [13:0]      row_idx_reg, row_idx_next;
    logic [15:0]      blk_left_reg, blk_left_next;
    logic [RAW_W-1:0] raw_left_reg, raw_left_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      alo_reg, alo_next;
    logic [15:0]      ahi_reg, ahi_next;
    logic [RAW_W-1:0] raw_len_reg;
    logic [RAW_W-1:0] blocks_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             run_last_reg, run_last_next;
    logic             file_last_reg, file_last_next;

    logic             idle, out_free, fire, crc_en;
    logic [3:0]       entry_ph, cur_ph, cur_cnt;
    logic             cur_filt;
    logic [7:0]       cur_pix, ob;
    logic [15:0]      blk_n, row_len;
    logic [30:0]      blk_num;
    logic [62:0]      blk_prod;
    logic [31:0]      zlen, crc_out, iend_crc;
    logic [16:0]      lo_sum, hi_sum, lo_mod;
    logic [14:0]      cfg_v;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign file_last = file_last_reg;

    assign idle     = (phase_reg == PH_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = idle && out_free;

    assign row_len  = 16'({width_reg, 1'b0}) + 16'(width_reg);
    assign zlen     = 32'(raw_len_reg) + 32'({blocks_reg, 2'b00}) + 32'(blocks_reg) + 32'd6;
    assign crc_out  = crc_reg ^ ALL_ONES;
    assign iend_crc = IEND_CRC;
    assign blk_n    = (raw_left_reg < RAW_W'(BLOCK_EFF)) ? raw_left_reg[15:0] : BLK_D;

    // pick the phase a new input starts in
    always_comb
    begin
        if (!started_reg)
            entry_ph = PH_SIG;
        else if (blk_left_reg == 16'd0)
            entry_ph = PH_BLKH;
        else if (row_pos_reg == 16'd0)
            entry_ph = PH_FILT;
        else
            entry_ph = PH_PIX;
    end

    assign cur_ph   = idle ? entry_ph : phase_reg;
    assign cur_cnt  = idle ? 4'd0 : cnt_reg;
    assign cur_filt = idle ? (row_pos_reg == 16'd0) : filt_reg;
    assign cur_pix  = idle ? pixel_byte : pix_reg;
    assign fire     = out_free && (!idle || in_valid);

    // Adler-32 update for the current data byte
    assign lo_sum = 17'(alo_reg) + 17'((cur_ph == PH_PIX) ? cur_pix : 8'd0);
    assign lo_mod = (lo_sum >= ADLER_MOD) ? (lo_sum - ADLER_MOD) : lo_sum;
    assign hi_sum = 17'(ahi_reg) + lo_mod;

    // byte sequencer: one output byte per fire
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        filt_next     = filt_reg;
        pix_next      = pix_reg;
        started_next  = started_reg;
        row_pos_next  = row_pos_reg;
        row_idx_next  = row_idx_reg;
        blk_left_next = blk_left_reg;
        raw_left_next = raw_left_reg;
        alo_next      = alo_reg;
        ahi_next      = ahi_reg;
        file_last_next = 1'b0;
        crc_en        = 1'b0;
        ob            = 8'd0;
        case (cur_ph)
            PH_SIG:
            begin
                case (cur_cnt[2:0])
                    3'd0:    ob = 8'd137;
                    3'd1:    ob = 8'd80;
                    3'd2:    ob = 8'd78;
                    3'd3:    ob = 8'd71;
                    3'd4:    ob = 8'd13;
                    3'd5:    ob = 8'd10;
                    3'd6:    ob = 8'd26;
                    default: ob = 8'd10;
                endcase
                phase_next = (cur_cnt == 4'd7) ? PH_IHLEN : PH_SIG;
            end
            PH_IHLEN:
            begin
                ob = (cur_cnt == 4'd3) ? 8'd13 : 8'd0;
                phase_next = (cur_cnt == 4'd3) ? PH_IHTAG : PH_IHLEN;
            end
            PH_IHTAG:
            begin
                case (cur_cnt[1:0])
                    2'd0:    ob = "I";
                    2'd1:    ob = "H";
                    2'd2:    ob = "D";
                    default: ob = "R";
                endcase
                crc_en = 1'b1;
                phase_next = (cur_cnt == 4'd3) ? PH_IHDAT : PH_IHTAG;
            end
            PH_IHDAT:
            begin
                case (cur_cnt)
                    4'd2:    ob = {1'b0, width_reg[14:8]};
                    4'd3:    ob = width_reg[7:0];
                    4'd6:    ob = {1'b0, height_reg[14:8]};
                    4'd7:    ob = height_reg[7:0];
                    4'd8:    ob = 8'd8;
                    4'd9:    ob = 8'd2;
                    default: ob = 8'd0;
                endcase
                crc_en = 1'b1;
                phase_next = (cur_cnt == 4'd12) ? PH_IHCRC : PH_IHDAT;
            end
            PH_IHCRC:
            begin
                case (cur_cnt[1:0])
                    2'd0:    ob = crc_out[31:24];
                    2'd1:    ob = crc_out[23:16];
                    2'd2:    ob = crc_out[15:8];
                    default: ob = crc_out[7:0];
                endcase
                phase_next = (cur_cnt == 4'd3) ? PH_ZLEN : PH_IHCRC;
            end
            PH_ZLEN:
            begin
                case (cur_cnt[1:0])
                    2'd0:    ob = zlen[31:24];
                    2'd1:    ob = zlen[23:16];
                    2'd2:    ob = zlen[15:8];
                    default: ob = zlen[7:0];
                endcase
                phase_next = (cur_cnt == 4'd3) ? PH_IDTAG : PH_ZLEN;
            end
            PH_IDTAG:
            begin
                case (cur_cnt[1:0])
                    2'd0:    ob = "I";
                    2'd1:    ob = "D";
                    2'd2:    ob = "A";
                    default: ob = "T";
                endcase
                crc_en = 1'b1;
                phase_next = (cur_cnt == 4'd3) ? PH_ZHDR : PH_IDTAG;
            end
            PH_ZHDR:
            begin
                ob = (cur_cnt == 4'd0) ? 8'h78 : 8'h01;
                crc_en = 1'b1;
                if (cur_cnt == 4'd1)
                begin
                    raw_left_next = raw_len_reg;
                    phase_next    = PH_BLKH;
                    filt_next     = 1'b1;
                end
            end
            PH_BLKH:
            begin
                case (cur_cnt[2:0])
                    3'd0:    ob = {7'd0, (RAW_W'(blk_n) == raw_left_reg)};
                    3'd1:    ob = blk_n[7:0];
                    3'd2:    ob = blk_n[15:8];
                    3'd3:    ob = ~blk_n[7:0];
                    default: ob = ~blk_n[15:8];
                endcase
                crc_en = 1'b1;
                filt_next = cur_filt;
                if (cur_cnt == 4'd4)
                begin
                    blk_left_next = blk_n;
                    phase_next    = cur_filt ? PH_FILT : PH_PIX;
                end
                else
                begin
                    phase_next = PH_BLKH;
                end
            end
            PH_FILT, PH_PIX:
            begin
                ob = (cur_ph == PH_PIX) ? cur_pix : 8'd0;
                crc_en        = 1'b1;
                alo_next      = lo_mod[15:0];
                ahi_next      = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
                blk_left_next = blk_left_reg - 16'd1;
                raw_left_next = raw_left_reg - RAW_W'(1);
                if (cur_ph == PH_FILT)
                begin
                    filt_next  = 1'b0;
                    phase_next = (blk_left_reg == 16'd1) ? PH_BLKH : PH_PIX;
                end
                else
                begin
                    if (row_pos_reg + 16'd1 >= row_len)
                    begin
                        row_pos_next = 16'd0;
                        row_idx_next = row_idx_reg + 14'd1;
                    end
                    else
                    begin
                        row_pos_next = row_pos_reg + 16'd1;
                    end
                    phase_next = (raw_left_reg == RAW_W'(1)) ? PH_ADLER : PH_IDLE;
                end
            end
            PH_ADLER:
            begin
                case (cur_cnt[1:0])
                    2'd0:    ob = ahi_reg[15:8];
                    2'd1:    ob = ahi_reg[7:0];
                    2'd2:    ob = alo_reg[15:8];
                    default: ob = alo_reg[7:0];
                endcase
                crc_en = 1'b1;
                phase_next = (cur_cnt == 4'd3) ? PH_DCRC : PH_ADLER;
            end
            PH_DCRC:
            begin
                case (cur_cnt[1:0])
                    2'd0:    ob = crc_out[31:24];
                    2'd1:    ob = crc_out[23:16];
                    2'd2:    ob = crc_out[15:8];
                    default: ob = crc_out[7:0];
                endcase
                phase_next = (cur_cnt == 4'd3) ? PH_IEND : PH_DCRC;
            end
            PH_IEND:
            begin
                case (cur_cnt)
                    4'd4:    ob = "I";
                    4'd5:    ob = "E";
                    4'd6:    ob = "N";
                    4'd7:    ob = "D";
                    4'd8:    ob = iend_crc[31:24];
                    4'd9:    ob = iend_crc[23:16];
                    4'd10:   ob = iend_crc[15:8];
                    4'd11:   ob = iend_crc[7:0];
                    default: ob = 8'd0;
                endcase
                if (cur_cnt == 4'd11)
                begin
                    file_last_next = 1'b1;
                    phase_next     = PH_IDLE;
                    started_next   = 1'b0;
                    alo_next       = 16'd1;
                    ahi_next       = 16'd0;
                    row_pos_next   = 16'd0;
                    row_idx_next   = 14'd0;
                    blk_left_next  = 16'd0;
                    raw_left_next  = '0;
                end
                else
                begin
                    phase_next = PH_IEND;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // counter restarts whenever the phase changes
        cnt_next = (phase_next == cur_ph) ? (cur_cnt + 4'd1) : 4'd0;

        // image start: mark started, reset the row and block counters and the running sums
        if (cur_ph == PH_SIG && cur_cnt == 4'd0)
        begin
            started_next  = 1'b1;
            row_pos_next  = 16'd0;
            row_idx_next  = 14'd0;
            blk_left_next = 16'd0;
            alo_next      = 16'd1;
            ahi_next      = 16'd0;
        end

        // CRC: restart before IHDR and IDAT, clear after the IDAT CRC
        if (crc_en)
            crc_next = crc_feed(((cur_ph == PH_IHTAG || cur_ph == PH_IDTAG) && cur_cnt == 4'd0)
                                ? ALL_ONES : crc_reg, ob);
        else if (cur_ph == PH_DCRC && cur_cnt == 4'd3)
            crc_next = ALL_ONES;
        else
            crc_next = crc_reg;

        if (idle)
            pix_next = pixel_byte;

        out_byte_next = ob;
        run_last_next = (phase_next == PH_IDLE);
    end

    // configuration writes, clamped, dropped during an image
    assign cfg_v = (cfg_data == 15'd0) ? 15'd1 : cfg_data;
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && !started_reg)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:
                    width_next = (cfg_v > 15'(WIDTH_MAX)) ? 15'(WIDTH_MAX) : cfg_v;
                CFG_IDX_HEIGHT:
                    height_next = (cfg_v > 15'(HEIGHT_MAX)) ? 15'(HEIGHT_MAX) : cfg_v;
                default:
                    width_next = width_reg;
            endcase
        end
    end

    // block count: round the raw length up, then multiply by the reciprocal
    assign blk_num  = 31'(raw_len_reg) + 31'(BLOCK_EFF - 1);
    assign blk_prod = {32'd0, blk_num} * {31'd0, DIV_M};

    // raw length product at image start, block count registered in the cycle after
    always_ff @(posedge clk)
    begin
        if (fire && cur_ph == PH_SIG && cur_cnt == 4'd0)
        begin
            raw_len_reg <= RAW_W'(height_reg) * (RAW_W'(row_len) + RAW_W'(1));
        end
        blocks_reg <= RAW_W'(blk_prod >> DIV_SH);
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 15'd1;
            height_reg    <= 15'd1;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= 4'd0;
            filt_reg      <= 1'b0;
            started_reg   <= 1'b0;
            row_pos_reg   <= 16'd0;
            row_idx_reg   <= 14'd0;
            blk_left_reg  <= 16'd0;
            raw_left_reg  <= '0;
            crc_reg       <= ALL_ONES;
            alo_reg       <= 16'd1;
            ahi_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
            run_last_reg  <= 1'b0;
            file_last_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            if (fire)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                filt_reg      <= filt_next;
                started_reg   <= started_next;
                row_pos_reg   <= row_pos_next;
                row_idx_reg   <= row_idx_next;
                blk_left_reg  <= blk_left_next;
                raw_left_reg  <= raw_left_next;
                crc_reg       <= crc_next;
                alo_reg       <= alo_next;
                ahi_reg       <= ahi_next;
                run_last_reg  <= run_last_next;
                file_last_reg <= file_last_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= out_byte_next;
            pix_reg      <= pix_next;
        end
    end

endmodule

// ===== src/pngse_checker.sv =====
// Port-level checks for the PNG stored-stream encoder core, and their bind.
// Depends only on the core's ports.
module pngse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       file_last
);

    // hold a stalled output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("stalled output byte changed");

    // the file end closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && file_last |-> run_last)
        else $error("file_last without run_last");

    // every input transaction shows a byte on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input accepted without output");

    // no new input while a run still has bytes to send
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
        else $error("input taken in the middle of a run");

endmodule

bind png_stored_stream_encoder_core pngse_checker u_pngse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .file_last (file_last)
);
